@@ design/hlbc_pkg.sv @@
// package for the hashed lru buffer cache
// holds status and command codes shared by controller, datapath and top
`default_nettype none
package hlbc_pkg;
  typedef enum logic [1:0] {
    CMD_GET = 2'd0, CMD_RELEASE = 2'd1, CMD_PIN = 2'd2, CMD_UNPIN = 2'd3
  } cmd_t;
  localparam logic [2:0] ST_HIT   = 3'd0;
  localparam logic [2:0] ST_MISS  = 3'd1;
  localparam logic [2:0] ST_NOBUF = 3'd2;
  localparam logic [2:0] ST_DONE  = 3'd3;
  localparam logic [2:0] ST_ERR   = 3'd4;
  // controller to datapath commands
  typedef struct packed {
    logic load;     // capture request and set index
    logic decide;   // read set row into the row register
    logic commit;   // register result and updated row, arm set row write back
    logic clear;    // reset sweep writes one set
  } ctl_t;
  typedef struct packed {
    logic clear_last;
  } sts_t;
endpackage
`default_nettype wire

@@ design/hlbc_ctrl.sv @@
// controller state machine for the hashed lru buffer cache
// depends on hlbc_pkg; drives the datapath through ctl_t
`default_nettype none
module hlbc_ctrl
  import hlbc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  output ctl_t      ctl,
  input  wire sts_t sts
);
  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_READ, S_DECIDE, S_OUT} state_t;
  state_t state_r;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  always_comb begin
    ctl.load   = (state_r == S_IDLE) && in_valid;
    ctl.decide = (state_r == S_READ);
    ctl.commit = (state_r == S_DECIDE);
    ctl.clear  = (state_r == S_CLEAR);
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      unique case (state_r)
        S_CLEAR:  if (sts.clear_last) state_r <= S_IDLE;
        S_IDLE:   if (in_valid) state_r <= S_READ;
        S_READ:   state_r <= S_DECIDE;
        S_DECIDE: state_r <= S_OUT;
        S_OUT:    if (out_ready) state_r <= S_IDLE;
        default:  state_r <= S_CLEAR;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ design/hlbc_datapath.sv @@
// datapath: set memory, tag compare, lru pick and write back
// depends on hlbc_pkg; one memory row holds all ways of a set
`default_nettype none
module hlbc_datapath
  import hlbc_pkg::*;
#(
  parameter int BUCKETS = 17,
  parameter int WAYS    = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire ctl_t        ctl,
  output sts_t             sts,
  input  wire logic [1:0]  in_command,
  input  wire logic [7:0]  in_device,
  input  wire logic [31:0] in_block_number,
  input  wire logic [7:0]  in_slot,
  output logic [2:0]       out_status,
  output logic [7:0]       out_slot_out,
  output logic             out_needs_fill,
  output logic [7:0]       out_ref_count
);
  localparam int SW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int WW = $clog2(WAYS);
  localparam int ENTRIES = BUCKETS * WAYS;

  typedef struct packed {
    logic [7:0]    dev;
    logic [31:0]   blk;
    logic          valid;
    logic [7:0]    cnt;
    logic [WW-1:0] rank;
  } entry_t;
  typedef entry_t [WAYS-1:0] row_t;

  row_t mem [BUCKETS];
  row_t row_r, row_nxt;
  logic [SW-1:0] set_r, clr_r;
  logic [1:0]    cmd_r;
  logic [7:0]    dev_r, slot_r;
  logic [31:0]   blk_r;
  logic [WW-1:0] way_r;
  logic          bad_r;
  logic [2:0]    st_r, st_nxt;
  logic [7:0]    so_r, so_nxt, rc_r, rc_nxt;
  logic          nf_r, nf_nxt, wr_r, wr_nxt;

  // block number mod BUCKETS, one step per bit is too slow; use a constant
  // reciprocal: q = floor(blk * M >> (32 + RS)), exact for 32-bit blk
  localparam int RS = $clog2(BUCKETS);
  localparam logic [33:0] RECIP = 34'((66'd1 << (32 + RS)) / BUCKETS + 1);
  logic [31:0] rem_w;
  logic [65:0] prod_w;
  logic [31:0] q_w;
  logic [31:0] r0_w;
  always_comb begin
    prod_w = 66'(in_block_number) * 66'(RECIP);
    q_w    = 32'(prod_w >> (32 + RS));
    r0_w   = in_block_number - 32'(64'(q_w) * 64'(BUCKETS));
    rem_w  = (r0_w >= 32'(BUCKETS)) ? r0_w - 32'(BUCKETS) : r0_w;
  end

  // slot split: slot / WAYS, WAYS need not be a power of two here
  logic [SW-1:0] sset_w;
  logic [WW-1:0] sway_w;
  logic          sbad_w;
  always_comb begin
    sset_w = '0;
    sway_w = '0;
    for (int b = 0; b < BUCKETS; b++) begin
      if (in_slot >= 8'(b * WAYS) && in_slot < 8'((b + 1) * WAYS)) begin
        sset_w = SW'(b);
        sway_w = WW'(in_slot - 8'(b * WAYS));
      end
    end
    sbad_w = (9'(in_slot) >= 9'(ENTRIES));
  end

  // capture request
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r  <= in_command;
      dev_r  <= in_device;
      blk_r  <= in_block_number;
      slot_r <= in_slot;
      way_r  <= sway_w;
      bad_r  <= sbad_w;
      set_r  <= (in_command == CMD_GET) ? SW'(rem_w) : sset_w;
    end
  end

  // clearing sweep after reset, one set per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) clr_r <= '0;
    else if (ctl.clear) clr_r <= clr_r + SW'(1);
  end
  assign sts.clear_last = (32'(clr_r) == 32'(BUCKETS - 1));

  row_t clr_row;
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      clr_row[w]      = '0;
      clr_row[w].rank = WW'(w);
    end
  end

  // memory write port
  always_ff @(posedge clk) begin
    if (ctl.clear) mem[clr_r] <= clr_row;
    else if (wr_r) mem[set_r] <= row_r;
  end

  // decide on registered row
  logic          hit, free;
  logic [WW-1:0] hw, fw, tw;
  logic [WW-1:0] hbest, fbest;
  always_comb begin
    hit = 1'b0; free = 1'b0; hw = '0; fw = '0; hbest = '0; fbest = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (row_r[w].dev == dev_r && row_r[w].blk == blk_r &&
          (!hit || row_r[w].rank > hbest)) begin
        hit = 1'b1; hbest = row_r[w].rank; hw = WW'(w);
      end
      if (row_r[w].cnt == 8'd0 && (!free || row_r[w].rank < fbest)) begin
        free = 1'b1; fbest = row_r[w].rank; fw = WW'(w);
      end
    end
    row_nxt = row_r;
    st_nxt = ST_DONE; so_nxt = slot_r; nf_nxt = 1'b0; rc_nxt = 8'd0; wr_nxt = 1'b0;
    tw = way_r;
    if (cmd_r == CMD_GET) begin
      if (hit) begin
        tw = hw;
        st_nxt = ST_HIT;
        nf_nxt = !row_r[hw].valid;
        if (row_r[hw].cnt != 8'hff) row_nxt[hw].cnt = row_r[hw].cnt + 8'd1;
        row_nxt[hw].valid = 1'b1;
        rc_nxt = row_nxt[hw].cnt;
        wr_nxt = 1'b1;
      end else if (free) begin
        tw = fw;
        st_nxt = ST_MISS;
        nf_nxt = 1'b1;
        rc_nxt = 8'd1;
        row_nxt[fw].dev = dev_r;
        row_nxt[fw].blk = blk_r;
        row_nxt[fw].cnt = 8'd1;
        row_nxt[fw].valid = 1'b1;
        wr_nxt = 1'b1;
      end else begin
        st_nxt = ST_NOBUF;
      end
      so_nxt = 8'(32'(set_r) * WAYS + 32'(tw));
      if (st_nxt == ST_NOBUF) so_nxt = 8'd0;
    end else if (bad_r) begin
      st_nxt = ST_ERR;
    end else if (cmd_r == CMD_PIN) begin
      if (row_r[tw].cnt != 8'hff) row_nxt[tw].cnt = row_r[tw].cnt + 8'd1;
      rc_nxt = row_nxt[tw].cnt;
      wr_nxt = 1'b1;
    end else if (row_r[tw].cnt == 8'd0) begin
      st_nxt = ST_ERR;
    end else begin
      row_nxt[tw].cnt = row_r[tw].cnt - 8'd1;
      rc_nxt = row_nxt[tw].cnt;
      wr_nxt = 1'b1;
      // release to zero moves entry to most recent
      if (cmd_r == CMD_RELEASE && row_nxt[tw].cnt == 8'd0) begin
        for (int w = 0; w < WAYS; w++) begin
          if (row_r[w].rank > row_r[tw].rank) row_nxt[w].rank = row_r[w].rank - WW'(1);
        end
        row_nxt[tw].rank = WW'(WAYS - 1);
      end
    end
  end

  // set row read, result and write-back registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r <= 1'b0;
    end else begin
      wr_r <= ctl.commit && wr_nxt;
    end
    if (ctl.decide) row_r <= mem[set_r];
    else if (ctl.commit) row_r <= row_nxt;
    if (ctl.commit) begin
      st_r <= st_nxt; so_r <= so_nxt; nf_r <= nf_nxt; rc_r <= rc_nxt;
    end
  end

  assign out_status     = st_r;
  assign out_slot_out   = so_r;
  assign out_needs_fill = nf_r;
  assign out_ref_count  = rc_r;
endmodule
`default_nettype wire

@@ design/hashed_lru_buffer_cache.sv @@
// top level of the hashed lru buffer cache
// depends on hlbc_pkg, hlbc_ctrl and hlbc_datapath
`default_nettype none
// Tag and replacement engine for a hashed set-associative block cache. A
// command is taken in at one edge, the set row is read, then the result is
// decided and registered and held until it is transferred out. The single
// set memory port is read and then written back, so the next command is
// taken the cycle after the result is transferred; a new command is not
// taken while one is in flight or its result waits. After reset a clearing
// pass writes every set, one set per cycle, before the first command is
// accepted.
module hashed_lru_buffer_cache
  import hlbc_pkg::*;
#(
  parameter int BUCKETS = 17,
  parameter int WAYS    = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_command,
  input  wire logic [7:0]  in_device,
  input  wire logic [31:0] in_block_number,
  input  wire logic [7:0]  in_slot,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_status,
  output logic [7:0]       out_slot_out,
  output logic             out_needs_fill,
  output logic [7:0]       out_ref_count
);
  ctl_t ctl;
  sts_t sts;

  hlbc_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .ctl, .sts
  );

  hlbc_datapath #(.BUCKETS(BUCKETS), .WAYS(WAYS)) u_dp (
    .clk, .rst_n, .ctl, .sts, .in_command, .in_device, .in_block_number,
    .in_slot, .out_status, .out_slot_out, .out_needs_fill, .out_ref_count
  );
endmodule
`default_nettype wire

@@ design/hlbc_checker.sv @@
// port checker for the hashed lru buffer cache
// depends on hlbc_pkg and the top level ports; bound to the top level below
`default_nettype none
module hlbc_checker
  import hlbc_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [2:0] out_status,
  input wire logic       out_needs_fill,
  input wire logic [7:0] out_ref_count
);
  // no new transfer in while a result waits
  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken with result pending");
  // a transfer in leads to a result after the read and decide states
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> ##2 out_valid) else $error("result late");
  // a miss always needs a fill with count one
  a_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_MISS) |-> (out_needs_fill && out_ref_count == 8'd1))
    else $error("bad miss result");
  // valid and status hold while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_status)))
    else $error("result dropped");
endmodule

bind hashed_lru_buffer_cache hlbc_checker u_chk (
  .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
  .out_status, .out_needs_fill, .out_ref_count
);
`default_nettype wire

@@ test/tb_hashed_lru_buffer_cache.sv @@
// testbench for the hashed lru buffer cache tag and replacement engine
// depends on hlbc_pkg and hashed_lru_buffer_cache; checks against its own predictor
`timescale 1ns / 1ps
module tb_hashed_lru_buffer_cache
  import hlbc_pkg::*;
();

  localparam int NSETS    = 17;
  localparam int NWAYS    = 8;
  localparam int NENTRIES = NSETS * NWAYS;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] slot_out;
    logic       needs_fill;
    logic [7:0] ref_count;
  } cache_reply_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_command = CMD_GET;
  logic [7:0] in_device = '0;
  logic [31:0] in_block_number = '0;
  logic [7:0] in_slot = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] out_status;
  logic [7:0] out_slot_out;
  logic out_needs_fill;
  logic [7:0] out_ref_count;

  // predictor copy of the entry state
  logic [7:0]  pred_dev [NENTRIES];
  logic [31:0] pred_blk [NENTRIES];
  logic        pred_valid [NENTRIES];
  logic [7:0]  pred_cnt [NENTRIES];
  int          pred_rank [NENTRIES];

  cache_reply_t expected_replies[$];
  int errors = 0;
  int cycles = 0;
  bit quiet_sender = 1'b0;   // no idling stretch
  bit quiet_receiver = 1'b0;
  int hold_receiver = 0;     // long receiver hold-off, in cycles
  int hold_requests = 0;     // hold-offs asked for by the tests
  int hold_seen = 0;         // hold-offs started by the receiver
  bit draining = 1'b0;

  hashed_lru_buffer_cache i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_command(in_command),
    .in_device(in_device), .in_block_number(in_block_number), .in_slot(in_slot),
    .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
    .out_slot_out(out_slot_out), .out_needs_fill(out_needs_fill),
    .out_ref_count(out_ref_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("hashed_lru_buffer_cache test failed");
      $finish;
    end
  end

  function automatic void clear_cache_state();
    for (int i = 0; i < NENTRIES; i++) begin
      pred_dev[i] = '0;
      pred_blk[i] = '0;
      pred_valid[i] = 1'b0;
      pred_cnt[i] = '0;
      pred_rank[i] = i % NWAYS;
    end
  endfunction

  // work out the reply of one command and update the predicted state
  function automatic cache_reply_t predict_cache_reply(cmd_t cmd, logic [7:0] dev,
                                                       logic [31:0] blk, logic [7:0] slot);
    cache_reply_t r;
    int base;
    int pick;
    int best;
    bit found;
    r = '0;
    found = 1'b0;
    pick = 0;
    best = 0;
    if (cmd == CMD_GET) begin
      base = (blk % NSETS) * NWAYS;
      // tag match, most recent wins
      for (int w = 0; w < NWAYS; w++) begin
        if (pred_dev[base+w] == dev && pred_blk[base+w] == blk &&
            (!found || pred_rank[base+w] > best)) begin
          found = 1'b1;
          best = pred_rank[base+w];
          pick = base + w;
        end
      end
      if (found) begin
        r.needs_fill = !pred_valid[pick];
        if (pred_cnt[pick] != 8'hff) pred_cnt[pick]++;
        pred_valid[pick] = 1'b1;
        r.status = ST_HIT;
        r.slot_out = 8'(pick);
        r.ref_count = pred_cnt[pick];
        return r;
      end
      // least recent free entry
      for (int w = 0; w < NWAYS; w++) begin
        if (pred_cnt[base+w] == 0 && (!found || pred_rank[base+w] < best)) begin
          found = 1'b1;
          best = pred_rank[base+w];
          pick = base + w;
        end
      end
      if (!found) begin
        r.status = ST_NOBUF;
        return r;
      end
      pred_dev[pick] = dev;
      pred_blk[pick] = blk;
      pred_cnt[pick] = 8'd1;
      pred_valid[pick] = 1'b1;
      r.status = ST_MISS;
      r.slot_out = 8'(pick);
      r.needs_fill = 1'b1;
      r.ref_count = 8'd1;
      return r;
    end
    r.slot_out = slot;
    if (slot >= NENTRIES) begin
      r.status = ST_ERR;
      return r;
    end
    if (cmd == CMD_PIN) begin
      if (pred_cnt[slot] != 8'hff) pred_cnt[slot]++;
      r.status = ST_DONE;
      r.ref_count = pred_cnt[slot];
      return r;
    end
    if (pred_cnt[slot] == 0) begin
      r.status = ST_ERR;
      return r;
    end
    pred_cnt[slot]--;
    if (cmd == CMD_RELEASE && pred_cnt[slot] == 0) begin
      base = (slot / NWAYS) * NWAYS;
      best = pred_rank[slot];
      for (int w = 0; w < NWAYS; w++)
        if (pred_rank[base+w] > best) pred_rank[base+w]--;
      pred_rank[slot] = NWAYS - 1;
    end
    r.status = ST_DONE;
    r.ref_count = pred_cnt[slot];
    return r;
  endfunction

  // send one command, with random idle before it
  task automatic send_command(cmd_t cmd, logic [7:0] dev, logic [31:0] blk,
                              logic [7:0] slot);
    while (!quiet_sender && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_device <= dev;
    in_block_number <= blk;
    in_slot <= slot;
    do @(posedge clk); while (!in_ready);
    expected_replies.push_back(predict_cache_reply(cmd, dev, blk, slot));
  endtask

  task automatic wait_all_replies();
    in_valid <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk);
  endtask

  // receiver ready, with random stalls and one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_requests != hold_seen) begin
      hold_seen <= hold_requests;
      hold_receiver <= 60;
      out_ready <= 1'b0;
    end else if (hold_receiver > 0) begin
      hold_receiver <= hold_receiver - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= quiet_receiver || draining || ($urandom_range(99) >= 12);
    end
  end

  // reply checker
  always @(posedge clk) begin
    cache_reply_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (expected_replies.size() == 0) begin
        $display("%0t: unexpected transfer status %0d slot %0d", $time, out_status,
                 out_slot_out);
        errors++;
      end else begin
        exp_r = expected_replies.pop_front();
        if (out_status !== exp_r.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_r.status, out_status);
          errors++;
        end
        if (out_slot_out !== exp_r.slot_out) begin
          $display("%0t: slot_out expected %0d actual %0d", $time, exp_r.slot_out,
                   out_slot_out);
          errors++;
        end
        if (out_needs_fill !== exp_r.needs_fill) begin
          $display("%0t: needs_fill expected %0d actual %0d", $time, exp_r.needs_fill,
                   out_needs_fill);
          errors++;
        end
        if (out_ref_count !== exp_r.ref_count) begin
          $display("%0t: ref_count expected %0d actual %0d", $time, exp_r.ref_count,
                   out_ref_count);
          errors++;
        end
      end
    end
  end

  // field extremes, each command, underflow, out-of-range slot
  task automatic test_directed();
    send_command(CMD_GET, 8'h00, 32'h0, 8'h00);          // hit on reset tag, needs fill
    send_command(CMD_GET, 8'hff, 32'hffff_ffff, 8'hff);  // miss
    send_command(CMD_PIN, 8'h00, 32'h0, 8'd0);
    send_command(CMD_UNPIN, 8'h00, 32'h0, 8'd0);
    send_command(CMD_RELEASE, 8'h00, 32'h0, 8'd0);       // back to zero, goes recent
    send_command(CMD_RELEASE, 8'h00, 32'h0, 8'd0);       // underflow
    send_command(CMD_UNPIN, 8'h00, 32'h0, 8'd135);       // underflow at last entry
    send_command(CMD_PIN, 8'h00, 32'h0, 8'd136);         // out of range
    send_command(CMD_RELEASE, 8'h00, 32'h0, 8'hff);
    send_command(CMD_UNPIN, 8'h00, 32'h0, 8'hff);
    send_command(CMD_GET, 8'h00, 32'h0, 8'h00);          // hit, data now valid
    send_command(CMD_GET, 8'haa, 32'h5555_5555, 8'h55);
  endtask

  // fill one set until no buffer is free
  task automatic test_no_free_buffer();
    for (int i = 0; i < NWAYS + 2; i++)
      send_command(CMD_GET, 8'd7, 32'd3 + NSETS * (i + 1), 8'h00);
    for (int w = 0; w < NWAYS; w++)
      send_command(CMD_RELEASE, 8'h00, 32'h0, 8'(3 * NWAYS + w));
  endtask

  // pin one entry to saturation
  task automatic test_saturation();
    for (int i = 0; i < 258; i++) send_command(CMD_PIN, 8'h00, 32'h0, 8'd50);
    send_command(CMD_GET, pred_dev[50], pred_blk[50], 8'h00);
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    hold_requests++;
    for (int i = 0; i < 20; i++)
      send_command(cmd_t'($urandom_range(3)), 8'($urandom_range(3)),
                   32'($urandom_range(40)), 8'($urandom_range(NENTRIES - 1)));
    wait_all_replies();
  endtask

  // mostly get/release traffic on a small tag pool, some noise
  task automatic test_random(int n);
    int k;
    logic [7:0] s;
    for (int i = 0; i < n; i++) begin
      quiet_sender = (i >= n / 2) && (i < n / 2 + 150);
      quiet_receiver = quiet_sender;
      k = $urandom_range(99);
      s = 8'($urandom_range(NENTRIES - 1));
      if (k < 45)
        send_command(CMD_GET, 8'($urandom_range(3)), 32'($urandom_range(80)), 8'($urandom));
      else if (k < 75)
        send_command(CMD_RELEASE, 8'h00, 32'h0, s);
      else if (k < 83)
        send_command(CMD_PIN, 8'h00, 32'h0, s);
      else if (k < 91)
        send_command(CMD_UNPIN, 8'h00, 32'h0, s);
      else
        send_command(cmd_t'($urandom_range(3)), 8'($urandom), 32'($urandom), 8'($urandom));
      if (i == n / 4) wait_all_replies();
    end
    quiet_sender = 1'b0;
    quiet_receiver = 1'b0;
  endtask

  initial begin
    clear_cache_state();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_no_free_buffer();
    test_saturation();
    test_backpressure();
    test_random(800);
    draining = 1'b1;
    wait_all_replies();
    repeat (20) @(posedge clk);
    if (errors == 0 && expected_replies.size() == 0) begin
      $display("hashed_lru_buffer_cache test passed");
    end else begin
      $display("hashed_lru_buffer_cache test failed");
    end
    $finish;
  end
endmodule
